/* rtl/dpsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_pkg: shared types and constants of the dual encoder speed controller
// Timing constants, derived widths, register map and sequencer states.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  // timing and output limits
  localparam int RPM_WINDOW_MS   = 100;
  localparam int PID_INTERVAL_MS = 20;
  localparam logic [7:0] PWM_FLOOR = 8'd0;

  // rpm scale: pulses * 60000 / (window * ppr)
  localparam int SPD_SCALE = 60000;

  // derived widths
  localparam int WIN_CNT_W = $clog2(RPM_WINDOW_MS + 1);
  localparam int PID_CNT_W = $clog2(PID_INTERVAL_MS + 1);
  localparam int ACC_W     = 13;
  localparam int PPR_W     = 12;
  localparam int DEN_W     = PPR_W + WIN_CNT_W;
  localparam int SPD_W     = 16;
  localparam int NUM_W     = ACC_W + SPD_W;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INT_W     = 32;
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 33;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int APB_AW    = 5;

  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // register map, word index
  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_INT_FLOOR = 3'd4,
    REG_INT_CEIL  = 3'd5,
    REG_PWM_CEIL  = 3'd6,
    REG_PPR       = 3'd7
  } reg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPD_MUL,
    ST_SPD_CHK,
    ST_SPD_DIV,
    ST_SPD_WR,
    ST_PID_ERR,
    ST_PID_MP,
    ST_PID_MI,
    ST_PID_MD,
    ST_PID_SUM,
    ST_PID_OUT,
    ST_DONE
  } state_t;

endpackage

/* rtl/dual_encoder_pid_speed_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_encoder_pid_speed_control: two-wheel encoder speed measurement and PID
// Per-tick pulse accumulation, windowed rpm measurement, periodic PID duty.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the encoder pulses of both
// wheels; each item yields exactly one result item with both duties, both
// measured speeds and two flags. One item at a time is in work and s_tready is
// low until its result is loaded into the output register. A tick that closes
// the rpm window runs the 16-step restoring divider once per wheel (skipped
// when the speed saturates); a tick that runs the PID passes each wheel
// through the shared 17x33 multiplier. The registers may only be written
// while no item is in work.
module dual_encoder_pid_speed_control (
  input  logic        clk,
  input  logic        rst,
  // input item: [5:0] left_pulse_count, [11:6] right_pulse_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  // result item: [7:0] left_duty, [15:8] right_duty,
  // [31:16] left_speed, [47:32] right_speed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // result flags: [0] speed_updated, [1] pid_updated
  output logic [1:0]  m_tuser,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dpsc_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dpsc_pkg::*;

  // configuration registers
  logic        [15:0]      target_speed;
  logic signed [15:0]      gain_p;
  logic signed [15:0]      gain_i;
  logic signed [15:0]      gain_d;
  logic signed [INT_W-1:0] integral_floor;
  logic signed [INT_W-1:0] integral_ceiling;
  logic        [7:0]       pwm_ceiling;
  logic        [PPR_W-1:0] pulses_per_rev;

  // control state
  state_t                 state;
  state_t                 state_next;
  logic [WIN_CNT_W-1:0]   win_cnt;
  logic [PID_CNT_W-1:0]   pid_cnt;
  logic                   win_hit;
  logic                   pid_hit;
  logic                   wheel;
  logic [3:0]             div_cnt;

  // per-wheel state
  logic        [ACC_W-1:0]  pulse_acc [2];
  logic        [SPD_W-1:0]  speed     [2];
  logic signed [INT_W-1:0]  integ_sum [2];
  logic signed [ERR_W-1:0]  prev_err  [2];
  logic        [7:0]        duty      [2];

  // datapath registers
  logic signed [PROD_W-1:0] mult_q;
  logic signed [PROD_W-1:0] sum_q;
  logic        [DEN_W-1:0]  rem;
  logic        [SPD_W-1:0]  quot;
  logic signed [ERR_W-1:0]  err_q;
  logic signed [INT_W-1:0]  integ_q;
  logic signed [DIFF_W-1:0] diff_q;

  // output register
  logic [47:0] out_data;
  logic [1:0]  out_user;

  logic accept;
  logic cfg_wr;
  logic out_load;

  assign accept   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed     <= '0;
      gain_p           <= '0;
      gain_i           <= '0;
      gain_d           <= '0;
      integral_floor   <= -32'sd1000000;
      integral_ceiling <= 32'sd1000000;
      pwm_ceiling      <= 8'd255;
      pulses_per_rev   <= PPR_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_TARGET:    target_speed     <= pwdata[15:0];
        REG_GAIN_P:    gain_p           <= pwdata[15:0];
        REG_GAIN_I:    gain_i           <= pwdata[15:0];
        REG_GAIN_D:    gain_d           <= pwdata[15:0];
        REG_INT_FLOOR: integral_floor   <= pwdata;
        REG_INT_CEIL:  integral_ceiling <= pwdata;
        REG_PWM_CEIL:  pwm_ceiling      <= pwdata[7:0];
        REG_PPR:       pulses_per_rev   <= pwdata[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_TARGET:    prdata = {16'd0, target_speed};
      REG_GAIN_P:    prdata = {16'd0, gain_p};
      REG_GAIN_I:    prdata = {16'd0, gain_i};
      REG_GAIN_D:    prdata = {16'd0, gain_d};
      REG_INT_FLOOR: prdata = integral_floor;
      REG_INT_CEIL:  prdata = integral_ceiling;
      REG_PWM_CEIL:  prdata = {24'd0, pwm_ceiling};
      REG_PPR:       prdata = {{(32-PPR_W){1'b0}}, pulses_per_rev};
      default:       prdata = '0;
    endcase
  end

  // divisor: window length times pulses per revolution, zero read as one
  logic [PPR_W-1:0] ppr_eff;
  logic [DEN_W-1:0] den;
  assign ppr_eff = (pulses_per_rev == '0) ? PPR_W'(1) : pulses_per_rev;
  assign den     = DEN_W'(RPM_WINDOW_MS) * DEN_W'(ppr_eff);

  // tick counters and pulse sums for the incoming item
  logic [WIN_CNT_W-1:0] win_cnt_inc;
  logic [PID_CNT_W-1:0] pid_cnt_inc;
  logic                 win_close;
  logic                 pid_close;
  logic [ACC_W:0]       acc_sum [2];
  logic [ACC_W-1:0]     acc_sat [2];

  assign win_cnt_inc = win_cnt + 1'b1;
  assign pid_cnt_inc = pid_cnt + 1'b1;
  assign win_close   = (win_cnt_inc >= WIN_CNT_W'(RPM_WINDOW_MS));
  assign pid_close   = (pid_cnt_inc >= PID_CNT_W'(PID_INTERVAL_MS));
  assign acc_sum[0]  = {1'b0, pulse_acc[0]} + (ACC_W+1)'(s_tdata[5:0]);
  assign acc_sum[1]  = {1'b0, pulse_acc[1]} + (ACC_W+1)'(s_tdata[11:6]);
  assign acc_sat[0]  = acc_sum[0][ACC_W] ? ACC_MAX : acc_sum[0][ACC_W-1:0];
  assign acc_sat[1]  = acc_sum[1][ACC_W] ? ACC_MAX : acc_sum[1][ACC_W-1:0];

  // shared multiplier operand select
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  product;

  always_comb begin
    unique case (state)
      ST_PID_MP: begin
        mul_a = MUL_A_W'(gain_p);
        mul_b = MUL_B_W'(err_q);
      end
      ST_PID_MI: begin
        mul_a = MUL_A_W'(gain_i);
        mul_b = MUL_B_W'(integ_q);
      end
      ST_PID_MD: begin
        mul_a = MUL_A_W'(gain_d);
        mul_b = MUL_B_W'(diff_q);
      end
      default: begin
        mul_a = MUL_A_W'(SPD_SCALE);
        mul_b = $signed({{(MUL_B_W-ACC_W){1'b0}}, pulse_acc[wheel]});
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // speed: saturation test and one restoring division step
  logic [ACC_W-1:0] num_hi;
  logic             spd_sat;
  logic [DEN_W:0]   trial;
  logic             trial_ge;

  assign num_hi   = mult_q[NUM_W-1:SPD_W];
  assign spd_sat  = (DEN_W'(num_hi) >= den);
  assign trial    = {rem, quot[SPD_W-1]};
  assign trial_ge = (trial >= (DEN_W+1)'(den));

  // pid: error, clamped integral, derivative term
  logic signed [ERR_W-1:0]  err;
  logic signed [INT_W:0]    integ_raw;
  logic signed [INT_W-1:0]  integ_clamp;

  assign err       = $signed({1'b0, target_speed}) - $signed({1'b0, speed[wheel]});
  assign integ_raw = (INT_W+1)'(integ_sum[wheel]) + (INT_W+1)'(err);

  always_comb begin
    priority if (integ_raw < (INT_W+1)'(integral_floor)) begin
      integ_clamp = integral_floor;
    end else if (integ_raw > (INT_W+1)'(integral_ceiling)) begin
      integ_clamp = integral_ceiling;
    end else begin
      integ_clamp = integ_raw[INT_W-1:0];
    end
  end

  // pid: floor shift and duty clamp
  logic signed [PROD_W-9:0] sum_shr;
  logic        [7:0]        duty_clamp;

  assign sum_shr = sum_q[PROD_W-1:8];

  always_comb begin
    priority if (sum_shr < $signed({{(PROD_W-16){1'b0}}, PWM_FLOOR})) begin
      duty_clamp = PWM_FLOOR;
    end else if (sum_shr > $signed({{(PROD_W-16){1'b0}}, pwm_ceiling})) begin
      duty_clamp = pwm_ceiling;
    end else begin
      duty_clamp = sum_shr[7:0];
    end
  end

  // sequencer: state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (win_close) begin
            state_next = ST_SPD_MUL;
          end else if (pid_close) begin
            state_next = ST_PID_ERR;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SPD_MUL: state_next = ST_SPD_CHK;
      ST_SPD_CHK: state_next = spd_sat ? ST_SPD_WR : ST_SPD_DIV;
      ST_SPD_DIV: begin
        if (div_cnt == '1) begin
          state_next = ST_SPD_WR;
        end
      end
      ST_SPD_WR: begin
        if (!wheel) begin
          state_next = ST_SPD_MUL;
        end else if (pid_hit) begin
          state_next = ST_PID_ERR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PID_ERR: state_next = ST_PID_MP;
      ST_PID_MP:  state_next = ST_PID_MI;
      ST_PID_MI:  state_next = ST_PID_MD;
      ST_PID_MD:  state_next = ST_PID_SUM;
      ST_PID_SUM: state_next = ST_PID_OUT;
      ST_PID_OUT: state_next = wheel ? ST_DONE : ST_PID_ERR;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers and per-wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      win_cnt <= '0;
      pid_cnt <= '0;
      win_hit <= 1'b0;
      pid_hit <= 1'b0;
      wheel   <= 1'b0;
      div_cnt <= '0;
      for (int i = 0; i < 2; i++) begin
        pulse_acc[i] <= '0;
        speed[i]     <= '0;
        integ_sum[i] <= '0;
        prev_err[i]  <= '0;
        duty[i]      <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            pulse_acc[0] <= acc_sat[0];
            pulse_acc[1] <= acc_sat[1];
            win_cnt      <= win_close ? '0 : win_cnt_inc;
            pid_cnt      <= pid_close ? '0 : pid_cnt_inc;
            win_hit      <= win_close;
            pid_hit      <= pid_close;
            wheel        <= 1'b0;
          end
        end
        ST_SPD_CHK: div_cnt <= '0;
        ST_SPD_DIV: div_cnt <= div_cnt + 1'b1;
        ST_SPD_WR: begin
          speed[wheel]     <= quot;
          pulse_acc[wheel] <= '0;
          wheel            <= !wheel;
        end
        ST_PID_OUT: begin
          duty[wheel]      <= duty_clamp;
          integ_sum[wheel] <= integ_q;
          prev_err[wheel]  <= err_q;
          wheel            <= !wheel;
        end
        default: ;
      endcase
    end
  end

  // shared datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_SPD_MUL: mult_q <= product;
      ST_SPD_CHK: begin
        rem  <= DEN_W'(num_hi);
        quot <= spd_sat ? '1 : mult_q[SPD_W-1:0];
      end
      ST_SPD_DIV: begin
        rem  <= trial_ge ? DEN_W'(trial - (DEN_W+1)'(den)) : trial[DEN_W-1:0];
        quot <= {quot[SPD_W-2:0], trial_ge};
      end
      ST_PID_ERR: begin
        err_q   <= err;
        integ_q <= integ_clamp;
        diff_q  <= DIFF_W'(err) - DIFF_W'(prev_err[wheel]);
      end
      ST_PID_MP: mult_q <= product;
      ST_PID_MI: begin
        sum_q  <= mult_q;
        mult_q <= product;
      end
      ST_PID_MD: begin
        sum_q  <= sum_q + mult_q;
        mult_q <= product;
      end
      ST_PID_SUM: sum_q <= sum_q + mult_q;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {speed[1], speed[0], duty[1], duty[0]};
      out_user <= {pid_hit, win_hit};
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again right after an item was accepted");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SPD_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_win_hit_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && win_hit |-> (win_cnt == '0))
    else $error("rpm window closed but window counter not cleared");

  a_pid_hit_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && pid_hit |-> (pid_cnt == '0))
    else $error("pid ran but interval counter not cleared");

  a_load_only_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken item");

endmodule
